// ===== rtl/mcr_pkg.sv =====
// Shared constants, item types and sequencer states for the least-rotation finder.
package mcr_pkg;

	localparam int MAX_LEN  = 256;
	localparam int CHAR_W   = 8;
	localparam int OUT_W    = 8;
	localparam int LEN_W    = $clog2(MAX_LEN + 1);
	localparam int ADDR_W   = $clog2(MAX_LEN);
	localparam int FT_DEPTH = 2 * MAX_LEN;
	localparam int FT_AW    = $clog2(FT_DEPTH);
	localparam int POS_W    = FT_AW + 1;
	localparam int FAIL_W   = POS_W;

	// failure-table entry meaning "no border", held as all ones
	localparam logic [FAIL_W-1:0] FAIL_NONE = '1;

	typedef struct packed {
		logic [CHAR_W-1:0] text_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] rotation_start;
		logic             too_long;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic             ack;
		logic [LEN_W-1:0] len;
	} scan_req_t;

	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] rot;
	} scan_rsp_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_RDJ,
		SC_GETI,
		SC_RDC,
		SC_CMP,
		SC_FOLLOW,
		SC_DONE
	} scan_state_t;

endpackage

// ===== rtl/min_cyclic_rotation_finder.sv =====
// Least cyclic rotation finder: byte loader, character store, scan and result register.
//
// Usage: the string arrives on the in channel, one byte per item, with
// last_byte set on the final byte. Bytes are loaded at one per cycle while not
// busy. Bytes past MAX_LEN are dropped and too_long is set in the result.
// After the final item the failure-function scan runs over the doubled string
// and in_ready stays low until the result has moved to the output register.
// The scan takes each position of the doubled string, 2n-1 positions for an
// n-byte string, through the states RDJ, GETI, RDC and CMP, and each step back
// along the border chain (at most 2n-1 such steps in total) through FOLLOW, RDC
// and CMP; its pace is set by the single read port of the failure-table RAM and
// of the character RAM, each with registered read data.
// One result item per string leaves on the out channel. It sits in the output
// register while the receiver stalls, and the next string may be loaded in the
// meantime; a following scan waits at its end until that register is free.
// Reset clears the length, overflow flag, sequencer and output valid; the
// character and failure-table RAMs need no clearing.
module min_cyclic_rotation_finder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcr_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mcr_pkg::out_item_t  out_item
);

	logic                       busy_q;
	logic [mcr_pkg::LEN_W-1:0]  len_q;
	logic                       ovf_q;
	logic                       out_valid_q;
	mcr_pkg::out_item_t         out_q;

	logic                       accept;
	logic                       wr_en;
	logic                       ack;
	mcr_pkg::scan_req_t         req;
	mcr_pkg::scan_rsp_t         rsp;
	logic [mcr_pkg::ADDR_W-1:0] char_raddr;
	logic [mcr_pkg::CHAR_W-1:0] char_rdata;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && (len_q < mcr_pkg::LEN_W'(mcr_pkg::MAX_LEN));
	assign ack      = rsp.done && (!out_valid_q || out_ready);

	assign req.start = accept && in_item.last_byte;
	assign req.ack   = ack;
	assign req.len   = len_q;

	mcr_ram #(
		.WIDTH(mcr_pkg::CHAR_W),
		.DEPTH(mcr_pkg::MAX_LEN)
	) u_char_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[mcr_pkg::ADDR_W-1:0]),
		.wdata(in_item.text_byte),
		.raddr(char_raddr),
		.rdata(char_rdata)
	);

	mcr_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.char_raddr(char_raddr),
		.char_rdata(char_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (wr_en) begin
					len_q <= len_q + mcr_pkg::LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (in_item.last_byte) begin
					busy_q <= 1'b1;
				end
			end
			if (ack) begin
				busy_q      <= 1'b0;
				len_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			out_q.rotation_start <= mcr_pkg::OUT_W'(rsp.rot);
			out_q.too_long       <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> busy_q)
		else $error("scan finished with no string loaded");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= mcr_pkg::LEN_W'(mcr_pkg::MAX_LEN))
		else $error("string length beyond store depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("result item changed while stalled");

endmodule

// ===== rtl/mcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mcr_scan.sv =====
// Booth failure-function scan over the doubled string, through the single read port of each RAM.
module mcr_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcr_pkg::scan_req_t            req,
	output mcr_pkg::scan_rsp_t            rsp,
	output logic [mcr_pkg::ADDR_W-1:0]    char_raddr,
	input  logic [mcr_pkg::CHAR_W-1:0]    char_rdata
);

	mcr_pkg::scan_state_t state_q, state_n;

	logic [mcr_pkg::POS_W-1:0]  j_q, j_n;
	logic [mcr_pkg::POS_W-1:0]  k_q, k_n;
	logic [mcr_pkg::FAIL_W-1:0] i_q, i_n;
	logic [mcr_pkg::CHAR_W-1:0] cj_q, cj_n;
	logic                       fv_q, fv_n;
	logic [mcr_pkg::POS_W-1:0]  hi_q, hi_n;
	logic                       any_q, any_n;
	logic                       zero_q, zero_n;

	logic [mcr_pkg::POS_W-1:0]  n_pos;
	logic [mcr_pkg::POS_W-1:0]  two_n;
	logic [mcr_pkg::POS_W-1:0]  x;
	logic [mcr_pkg::POS_W-1:0]  xm;
	logic [mcr_pkg::POS_W-1:0]  rd_idx;
	logic                       rd_ok;
	logic [mcr_pkg::POS_W-1:0]  w_idx;
	logic                       f_we;
	logic [mcr_pkg::FAIL_W-1:0] f_wdata;
	logic [mcr_pkg::FAIL_W-1:0] f_rdata;
	logic                       mism;
	logic                       less;

	assign n_pos = mcr_pkg::POS_W'(req.len);
	assign two_n = n_pos << 1;

	mcr_ram #(
		.WIDTH(mcr_pkg::FAIL_W),
		.DEPTH(mcr_pkg::FT_DEPTH)
	) u_fail_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(w_idx[mcr_pkg::FT_AW-1:0]),
		.wdata(f_wdata),
		.raddr(rd_idx[mcr_pkg::FT_AW-1:0]),
		.rdata(f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcr_pkg::SC_IDLE;
			j_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
			cj_q    <= '0;
			fv_q    <= 1'b0;
			hi_q    <= '0;
			any_q   <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			j_q     <= j_n;
			k_q     <= k_n;
			i_q     <= i_n;
			cj_q    <= cj_n;
			fv_q    <= fv_n;
			hi_q    <= hi_n;
			any_q   <= any_n;
			zero_q  <= zero_n;
		end
	end

	always_comb begin
		state_n = state_q;
		j_n     = j_q;
		k_n     = k_q;
		i_n     = i_q;
		cj_n    = cj_q;
		fv_n    = fv_q;
		hi_n    = hi_q;
		any_n   = any_q;
		zero_n  = zero_q;
		f_we    = 1'b0;
		f_wdata = i_q + mcr_pkg::FAIL_W'(1);
		x       = j_q;
		mism    = (cj_q != char_rdata);
		less    = (cj_q < char_rdata);

		// table reads: j-k-1 on a new position, else follow the border chain at i
		rd_idx = (state_q == mcr_pkg::SC_CMP) ? i_q : (j_q - k_q - mcr_pkg::POS_W'(1));
		// entries outside the span written in this scan read as no border
		rd_ok  = any_q && (rd_idx <= hi_q) && ((rd_idx != '0) || zero_q);

		case (state_q)
			mcr_pkg::SC_IDLE: begin
				if (req.start) begin
					j_n     = mcr_pkg::POS_W'(1);
					k_n     = '0;
					hi_n    = '0;
					any_n   = 1'b0;
					zero_n  = 1'b0;
					state_n = mcr_pkg::SC_RDJ;
				end
			end
			mcr_pkg::SC_RDJ: begin
				x       = j_q;
				fv_n    = rd_ok;
				state_n = mcr_pkg::SC_GETI;
			end
			mcr_pkg::SC_GETI: begin
				cj_n    = char_rdata;
				i_n     = fv_q ? f_rdata : mcr_pkg::FAIL_NONE;
				state_n = mcr_pkg::SC_RDC;
			end
			mcr_pkg::SC_RDC: begin
				// k+i+1, which wraps to k when i is no border
				x       = k_q + i_q + mcr_pkg::POS_W'(1);
				state_n = mcr_pkg::SC_CMP;
			end
			mcr_pkg::SC_CMP: begin
				if ((i_q != mcr_pkg::FAIL_NONE) && mism) begin
					if (less) begin
						k_n = j_q - i_q - mcr_pkg::POS_W'(1);
					end
					fv_n    = rd_ok;
					state_n = mcr_pkg::SC_FOLLOW;
				end else begin
					if ((i_q == mcr_pkg::FAIL_NONE) && mism) begin
						if (less) begin
							k_n = j_q;
						end
						f_wdata = mcr_pkg::FAIL_NONE;
					end
					f_we = 1'b0;
					f_we = 1'b1;
					j_n  = j_q + mcr_pkg::POS_W'(1);
					if (j_n == two_n) begin
						state_n = mcr_pkg::SC_DONE;
					end else begin
						state_n = mcr_pkg::SC_RDJ;
					end
				end
			end
			mcr_pkg::SC_FOLLOW: begin
				i_n     = fv_q ? f_rdata : mcr_pkg::FAIL_NONE;
				state_n = mcr_pkg::SC_RDC;
			end
			mcr_pkg::SC_DONE: begin
				if (req.ack) begin
					state_n = mcr_pkg::SC_IDLE;
				end
			end
			default: begin
				state_n = mcr_pkg::SC_IDLE;
			end
		endcase

		w_idx = j_q - k_n;
		// writes land on a contiguous span, so a high mark and a zero flag cover it
		if (f_we) begin
			if (!any_q || (w_idx > hi_q)) begin
				hi_n = w_idx;
			end
			any_n = 1'b1;
			if (w_idx == '0) begin
				zero_n = 1'b1;
			end
		end

		xm         = (x >= n_pos) ? (x - n_pos) : x;
		char_raddr = xm[mcr_pkg::ADDR_W-1:0];
	end

	assign rsp.done = (state_q == mcr_pkg::SC_DONE);
	assign rsp.rot  = (k_q >= n_pos) ? (k_q - n_pos) : k_q;

	a_cand_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcr_pkg::SC_RDJ) |-> (k_q < j_q))
		else $error("candidate start not behind scan position");

	a_cmp_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcr_pkg::SC_CMP && i_q != mcr_pkg::FAIL_NONE)
		|-> ((k_q + i_q + mcr_pkg::POS_W'(1)) < j_q))
		else $error("compare position not behind scan position");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mcr_pkg::SC_IDLE && state_q != mcr_pkg::SC_DONE) |-> (j_q < two_n))
		else $error("scan position past doubled string");

endmodule

// ===== test/tb_min_cyclic_rotation_finder.sv =====
// Self-checking testbench for the least cyclic rotation finder, with its own Booth scan predictor.
module tb_min_cyclic_rotation_finder;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	mcr_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	mcr_pkg::out_item_t out_item;

	min_cyclic_rotation_finder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// predictor copy of the string being loaded
	logic [7:0] text_store [mcr_pkg::MAX_LEN];
	int         text_len;
	logic       text_overflow;

	mcr_pkg::out_item_t rotation_q [$];
	logic [7:0]         text_buf [$];

	int error_count;
	int item_count;
	int string_count;
	int long_count;
	int result_count;
	int idle_pct;
	bit no_idle;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// failure table lookup, out of range reads as "no border"
	function automatic int border_at(ref int tab [2*mcr_pkg::MAX_LEN], input int idx);
		if (idx < 0 || idx >= 2 * mcr_pkg::MAX_LEN)
			return -1;
		return tab[idx];
	endfunction

	// Booth's scan over the doubled string, read modulo n
	function automatic logic [7:0] booth_min_rotation(input int n);
		int         tab [2*mcr_pkg::MAX_LEN];
		int         k;
		int         i;
		logic [7:0] cj;
		logic [7:0] ck;
		k = 0;
		for (int x = 0; x < 2 * mcr_pkg::MAX_LEN; x++)
			tab[x] = -1;
		for (int j = 1; j < 2 * n; j++) begin
			cj = text_store[j % n];
			i = border_at(tab, j - k - 1);
			while (i != -1 && cj != text_store[(k + i + 1) % n]) begin
				if (cj < text_store[(k + i + 1) % n])
					k = j - i - 1;
				i = border_at(tab, i);
			end
			ck = text_store[k % n];
			if (i == -1 && cj != ck) begin
				if (cj < ck)
					k = j;
				if (j - k >= 0 && j - k < 2 * mcr_pkg::MAX_LEN)
					tab[j - k] = -1;
			end else begin
				if (j - k >= 0 && j - k < 2 * mcr_pkg::MAX_LEN)
					tab[j - k] = i + 1;
			end
		end
		if (k < 0)
			k = 0;
		return 8'(k % n);
	endfunction

	// update the predictor with one accepted item
	task automatic note_accepted(input logic [7:0] b, input logic last);
		mcr_pkg::out_item_t res;
		item_count++;
		if (text_len < mcr_pkg::MAX_LEN) begin
			text_store[text_len] = b;
			text_len++;
		end else begin
			text_overflow = 1'b1;
		end
		if (last) begin
			res.rotation_start = booth_min_rotation(text_len);
			res.too_long       = text_overflow;
			rotation_q.insert(rotation_q.size(), res);
			string_count++;
			if (text_overflow)
				long_count++;
			text_len      = 0;
			text_overflow = 1'b0;
		end
	endtask

	// send one item; called and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid          = 1'b1;
		in_item.text_byte = b;
		in_item.last_byte = last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		note_accepted(b, last);
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int x = 0; x < text_buf.size(); x++)
			send_byte(text_buf[x], x == text_buf.size() - 1);
	endtask

	// fill text_buf: 0 any byte, 1 extremes only, 2 three low values, 3 periodic
	task automatic make_text(input int len, input int mode);
		int period;
		text_buf.delete();
		period = $urandom_range(1, 5);
		for (int x = 0; x < len; x++) begin
			case (mode)
				0: text_buf.insert(x, 8'($urandom_range(0, 255)));
				1: text_buf.insert(x, $urandom_range(0, 1) ? 8'hFF : 8'h00);
				2: text_buf.insert(x, 8'($urandom_range(0, 2)));
				default: begin
					if (x < period)
						text_buf.insert(x, 8'($urandom_range(0, 255)));
					else
						text_buf.insert(x, text_buf[x - period]);
				end
			endcase
		end
	endtask

	task automatic wait_results();
		in_valid = 1'b0;
		while (rotation_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		logic [7:0] words [9][$];
		words[0] = '{8'h00};
		words[1] = '{8'hFF};
		words[2] = '{8'h01, 8'h00};
		words[3] = '{8'h00, 8'hFF};
		words[4] = '{8'hFF, 8'h00, 8'hFF};
		words[5] = '{8'h07, 8'h07, 8'h07};
		words[6] = '{8'h62, 8'h61, 8'h62, 8'h61};
		words[7] = '{8'hFF, 8'hFF, 8'h00, 8'hFF};
		words[8] = '{8'h03, 8'h01, 8'h02, 8'h01, 8'h02};
		idle_pct = 30;
		foreach (words[w]) begin
			text_buf = words[w];
			send_text();
		end
		wait_results();
	endtask

	task automatic test_full_length();
		idle_pct = 10;
		make_text(mcr_pkg::MAX_LEN, 2);
		send_text();
	endtask

	// four bytes over the limit, the final byte among those dropped
	task automatic test_overflow();
		idle_pct = 10;
		make_text(mcr_pkg::MAX_LEN + 4, 3);
		send_text();
		wait_results();
	endtask

	task automatic test_random_strings(input int item_goal);
		int len;
		int r;
		idle_pct = 25;
		while (item_count < item_goal) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(13, 40);
			make_text(len, $urandom_range(0, 3));
			send_text();
			// occasional stretch with no gaps on the sending side
			if ($urandom_range(0, 9) == 0)
				idle_pct = (idle_pct == 0) ? 25 : 0;
		end
	endtask

	task automatic test_random_no_gaps(input int item_goal);
		no_idle = 1'b1;
		test_random_strings(item_goal);
	endtask

	// receiver stalls in bursts, and is always ready once no_idle is set
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (no_idle) begin
				out_ready = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		mcr_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (rotation_q.size() == 0) begin
				$display("%0t: result with none pending: rotation_start %0d too_long %0b",
					$time, out_item.rotation_start, out_item.too_long);
				error_count++;
			end else begin
				want = rotation_q.pop_front();
				if (out_item.rotation_start !== want.rotation_start) begin
					$display("%0t: rotation_start expected %0d, got %0d",
						$time, want.rotation_start, out_item.rotation_start);
					error_count++;
				end
				if (out_item.too_long !== want.too_long) begin
					$display("%0t: too_long expected %0b, got %0b",
						$time, want.too_long, out_item.too_long);
					error_count++;
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, rotation_q.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		text_len      = 0;
		text_overflow = 1'b0;
		error_count   = 0;
		item_count    = 0;
		string_count  = 0;
		long_count    = 0;
		result_count  = 0;
		idle_pct      = 0;
		no_idle       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_full_length();
		test_overflow();
		test_random_strings(item_count + 110);
		test_random_no_gaps(item_count + 50);

		in_valid = 1'b0;
		while (rotation_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d strings from %0d input items, %0d of them truncated; %0d results seen",
			string_count, item_count, long_count, result_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
